FILE: rtl/reaction_rate_constant_eval_unit_assert.svh
// assertion macros for the rate constant unit
`ifndef REACTION_RATE_CONSTANT_EVAL_UNIT_ASSERT_SVH
`define REACTION_RATE_CONSTANT_EVAL_UNIT_ASSERT_SVH

// implication checked outside reset
`define RRCE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked during reset
`define RRCE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/rrce_pkg.sv
package rrce_pkg;

  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_ARRH  = 2'd1;
  localparam logic [1:0] MODE_LFER  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_PREF  = 3'd1;
  localparam logic [2:0] REG_BASE  = 3'd2;
  localparam logic [2:0] REG_GAMMA = 3'd3;
  localparam logic [2:0] REG_DH    = 3'd4;
  localparam logic [2:0] REG_GAS   = 3'd5;

  // log2(e) - 1 in Q0.32, ln2 in Q0.32, one in Q2.62
  localparam logic [30:0] LOG2E_FRAC   = 31'd1901360723;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [63:0] ONE_Q62      = 64'h4000_0000_0000_0000;
  localparam int          SERIES_TERMS = 25;

  typedef enum logic [1:0] {
    K_NORM,
    K_CONST,
    K_ZERO,
    K_BIG
  } kind_t;

  typedef struct packed {
    logic  vld;
    logic  neg;
    kind_t kind;
  } side_t;

endpackage

FILE: rtl/rrce_front.sv
module rrce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic [19:0]         temperature,
  input  logic [1:0]          model_mode,
  input  logic [31:0]         base_energy,
  input  logic [16:0]         transfer_coeff,
  input  logic [31:0]         reaction_enthalpy,
  input  logic [31:0]         gas_constant,
  output rrce_pkg::side_t     side_o,
  output logic [48:0]         mag_o,
  output logic [51:0]         rt_o
);
  import rrce_pkg::*;

  logic [16:0]        gam_c;
  logic signed [49:0] gprod;
  logic signed [49:0] bse;
  logic signed [49:0] dhs;
  logic signed [49:0] e_lo;
  logic signed [49:0] e_cl;
  logic signed [49:0] e_fin;
  logic signed [49:0] e_abs;

  side_t              s1, s2, s3;
  logic [51:0]        rt1, rt2, rt3;
  logic signed [49:0] gdh1;
  logic signed [49:0] esum2;
  logic [48:0]        mag3;
  logic [57:0]        rt45_3;
  logic               big3;

  always_comb begin
    gam_c = (transfer_coeff > 17'd65536) ? 17'd65536 : transfer_coeff;
    gprod = $signed({1'b0, gam_c}) * $signed(reaction_enthalpy);
    bse   = $signed({{2{base_energy[31]}}, base_energy, 16'b0});
    dhs   = $signed({{2{reaction_enthalpy[31]}}, reaction_enthalpy, 16'b0});
    e_lo  = esum2[49] ? '0 : esum2;
    e_cl  = (e_lo < dhs) ? dhs : e_lo;
    e_fin = (model_mode == MODE_LFER) ? e_cl : esum2;
    e_abs = e_fin[49] ? -e_fin : e_fin;
  end

  assign big3 = (s3.kind == K_NORM) && ({9'b0, mag3} >= rt45_3);

  // stage 1: products and special-case kind
  always_ff @(posedge clk) begin
    s1.vld <= in_vld & ~rst;
    s1.neg <= 1'b0;
    if (model_mode != MODE_ARRH && model_mode != MODE_LFER) begin
      s1.kind <= K_CONST;
    end else if (temperature == '0 || gas_constant == '0) begin
      s1.kind <= K_ZERO;
    end else begin
      s1.kind <= K_NORM;
    end
    rt1  <= gas_constant * temperature;
    gdh1 <= gprod;
  end

  // stage 2: energy sum
  always_ff @(posedge clk) begin
    s2    <= '{vld: s1.vld & ~rst, neg: s1.neg, kind: s1.kind};
    rt2   <= rt1;
    esum2 <= (model_mode == MODE_LFER) ? bse + gdh1 : bse;
  end

  // stage 3: clamp and magnitude
  always_ff @(posedge clk) begin
    s3       <= '{vld: s2.vld & ~rst, neg: e_fin[49], kind: s2.kind};
    mag3     <= e_abs[48:0];
    rt3      <= rt2;
    rt45_3   <= rt2 * 6'd45;
  end

  // stage 4: large exponent check
  always_ff @(posedge clk) begin
    side_o <= '{vld: s3.vld & ~rst, neg: s3.neg, kind: big3 ? K_BIG : s3.kind};
    mag_o  <= mag3;
    rt_o   <= rt3;
  end

endmodule

FILE: rtl/rrce_div.sv
module rrce_div (
  input  logic            clk,
  input  logic            rst,
  input  rrce_pkg::side_t side_i,
  input  logic [48:0]     mag_i,
  input  logic [51:0]     rt_i,
  output rrce_pkg::side_t side_o,
  output logic [37:0]     q_o
);
  import rrce_pkg::*;

  localparam int STEPS     = 38;
  localparam int INT_STEPS = 6;

  side_t       sd  [1:STEPS];
  logic [57:0] rem [1:STEPS];
  logic [51:0] dv  [1:STEPS];
  logic [37:0] qq  [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    side_t       s_in;
    logic [57:0] r_in;
    logic [51:0] d_in;
    logic [37:0] q_in;
    logic [57:0] r_sh;
    logic [57:0] cand;

    if (i == 0) begin : g_first
      assign s_in = side_i;
      assign r_in = {9'b0, mag_i};
      assign d_in = rt_i;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = sd[i];
      assign r_in = rem[i];
      assign d_in = dv[i];
      assign q_in = qq[i];
    end

    // integer bits against shifted divisor, then one fraction bit a stage
    if (i < INT_STEPS) begin : g_int
      assign r_sh = r_in;
      assign cand = {6'b0, d_in} << (INT_STEPS - 1 - i);
    end else begin : g_frac
      assign r_sh = {r_in[56:0], 1'b0};
      assign cand = {6'b0, d_in};
    end

    always_ff @(posedge clk) begin
      sd[i+1] <= '{vld: s_in.vld & ~rst, neg: s_in.neg, kind: s_in.kind};
      dv[i+1] <= d_in;
      if (r_sh >= cand) begin
        rem[i+1] <= r_sh - cand;
        qq[i+1]  <= {q_in[36:0], 1'b1};
      end else begin
        rem[i+1] <= r_sh;
        qq[i+1]  <= {q_in[36:0], 1'b0};
      end
    end
  end

  assign side_o = sd[STEPS];
  assign q_o    = qq[STEPS];

endmodule

FILE: rtl/rrce_exp.sv
module rrce_exp (
  input  logic            clk,
  input  logic            rst,
  input  rrce_pkg::side_t side_i,
  input  logic [37:0]     t_i,
  output rrce_pkg::side_t side_o,
  output logic [6:0]      m_o,
  output logic [63:0]     f_o
);
  import rrce_pkg::*;

  typedef struct packed {
    side_t       side;
    logic [6:0]  m;
    logic [61:0] z;
    logic [63:0] sum;
  } carry_t;

  typedef struct packed {
    logic [15:0] q;
    logic [4:0]  r;
  } dstep_t;

  // one base-2^16 digit of a division by a small constant
  function automatic dstep_t div_digit(input logic [4:0] r, input logic [15:0] d,
                                       input logic [32:0] recip, input logic [4:0] n);
    logic [20:0] v;
    logic [53:0] prod;
    logic [20:0] back;
    dstep_t      res;
    v     = {r, d};
    prod  = v * recip;
    res.q = prod[47:32];
    back  = res.q * n;
    res.r = 5'(v - back);
    return res;
  endfunction

  // carry with its valid bit cleared in reset
  function automatic carry_t carry_gate(input carry_t c, input logic r);
    carry_t o;
    o          = c;
    o.side.vld = c.side.vld & ~r;
    return o;
  endfunction

  side_t       s1, s2;
  logic [37:0] t1;
  logic [62:0] p0;
  logic [36:0] p1;
  logic [71:0] full2;
  logic [6:0]  m2;
  logic [31:0] g2;
  logic [63:0] zprod;

  carry_t      cin [0:SERIES_TERMS];
  logic [63:0] tin [0:SERIES_TERMS-1];

  // t * log2(e): split so each product stays narrow
  always_ff @(posedge clk) begin
    s1 <= '{vld: side_i.vld & ~rst, neg: side_i.neg, kind: side_i.kind};
    t1 <= t_i;
    p0 <= t_i[31:0] * LOG2E_FRAC;
    p1 <= t_i[37:32] * LOG2E_FRAC;
  end

  assign full2 = {2'b0, t1, 32'b0} + {9'b0, p0} + {3'b0, p1, 32'b0};

  always_ff @(posedge clk) begin
    s2 <= '{vld: s1.vld & ~rst, neg: s1.neg, kind: s1.kind};
    m2 <= full2[70:64];
    g2 <= full2[63:32];
  end

  assign zprod = g2 * LN2_Q32;

  always_ff @(posedge clk) begin
    cin[0].side <= '{vld: s2.vld & ~rst, neg: s2.neg, kind: s2.kind};
    cin[0].m    <= m2;
    cin[0].z    <= zprod[63:2];
    cin[0].sum  <= ONE_Q62;
    tin[0]      <= ONE_Q62;
  end

  for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
    localparam int          N        = j + 1;
    localparam logic [32:0] RECIP    = 33'(((64'd1 << 32) + 64'(N) - 64'd1) / 64'(N));
    localparam logic [4:0]  NV       = 5'(N);
    localparam bit          ODD_TERM = (N % 2) == 1;

    carry_t       ca, cb;
    carry_t       cd   [1:4];
    carry_t       cnext;
    logic [63:0]  ll, lh, hl, hh;
    logic [127:0] prod;
    logic [63:0]  xb;
    logic [63:0]  xs   [1:3];
    logic [63:0]  qa   [1:4];
    logic [4:0]   rr   [1:3];
    dstep_t       dres [0:3];
    logic [31:0]  zh;

    assign zh = {2'b0, cin[j].z[61:32]};

    // term * z partial products
    always_ff @(posedge clk) begin
      ca <= carry_gate(cin[j], rst);
      ll <= tin[j][31:0]  * cin[j].z[31:0];
      lh <= tin[j][31:0]  * zh;
      hl <= tin[j][63:32] * cin[j].z[31:0];
      hh <= tin[j][63:32] * zh;
    end

    assign prod = {64'b0, ll} + {32'b0, lh, 32'b0} + {32'b0, hl, 32'b0} + {hh, 64'b0};

    always_ff @(posedge clk) begin
      cb <= carry_gate(ca, rst);
      xb <= prod[125:62];
    end

    always_comb begin
      dres[0] = div_digit(5'd0, xb[63:48], RECIP, NV);
      for (int k = 1; k < 4; k++) begin
        dres[k] = div_digit(rr[k], xs[k][63:48], RECIP, NV);
      end
    end

    // divide by n, most significant digit first
    always_ff @(posedge clk) begin
      cd[1] <= carry_gate(cb, rst);
      xs[1] <= {xb[47:0], 16'b0};
      qa[1] <= {48'b0, dres[0].q};
      rr[1] <= dres[0].r;
      for (int k = 1; k < 4; k++) begin
        cd[k+1] <= carry_gate(cd[k], rst);
        qa[k+1] <= {qa[k][47:0], dres[k].q};
      end
      for (int k = 1; k < 3; k++) begin
        xs[k+1] <= {xs[k][47:0], 16'b0};
        rr[k+1] <= dres[k].r;
      end
    end

    // accumulate, alternating sign for a positive energy
    always_comb begin
      cnext = carry_gate(cd[4], rst);
      if (ODD_TERM && !cd[4].side.neg) cnext.sum = cd[4].sum - qa[4];
      else cnext.sum = cd[4].sum + qa[4];
    end

    always_ff @(posedge clk) begin
      cin[j+1] <= cnext;
    end

    if (j < SERIES_TERMS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        tin[j+1] <= qa[4];
      end
    end
  end

  assign side_o = cin[SERIES_TERMS].side;
  assign m_o    = cin[SERIES_TERMS].m;
  assign f_o    = cin[SERIES_TERMS].sum;

endmodule

FILE: rtl/rrce_scale.sv
module rrce_scale (
  input  logic            clk,
  input  logic            rst,
  input  rrce_pkg::side_t side_i,
  input  logic [6:0]      m_i,
  input  logic [63:0]     f_i,
  input  logic [63:0]     prefactor,
  output logic            done,
  output logic [63:0]     rate_value,
  output logic [1:0]      status
);
  import rrce_pkg::*;

  side_t        s1, s2;
  logic [6:0]   m1, m2;
  logic [63:0]  ll, lh, hl, hh;
  logic [127:0] p2;
  logic [127:0] psum;
  logic [127:0] sh;
  logic [7:0]   rsh;
  logic [1:0]   lsh;
  logic         left;
  logic         sat;
  logic [63:0]  res;

  always_ff @(posedge clk) begin
    s1 <= '{vld: side_i.vld & ~rst, neg: side_i.neg, kind: side_i.kind};
    m1 <= m_i;
    ll <= prefactor[31:0]  * f_i[31:0];
    lh <= prefactor[31:0]  * f_i[63:32];
    hl <= prefactor[63:32] * f_i[31:0];
    hh <= prefactor[63:32] * f_i[63:32];
  end

  assign psum = {64'b0, ll} + {32'b0, lh, 32'b0} + {32'b0, hl, 32'b0} + {hh, 64'b0};

  always_ff @(posedge clk) begin
    s2 <= '{vld: s1.vld & ~rst, neg: s1.neg, kind: s1.kind};
    m2 <= m1;
    p2 <= psum;
  end

  // scale by 2^-(62+m) or 2^(m-62) with overflow check
  always_comb begin
    if (s2.neg) begin
      left = m2 > 7'd62;
      rsh  = 8'(7'd62 - m2);
      lsh  = 2'(m2 - 7'd62);
    end else begin
      left = 1'b0;
      rsh  = 8'd62 + {1'b0, m2};
      lsh  = '0;
    end
    sh = p2 >> rsh;
    if (left) begin
      sat = (lsh == 2'd1) ? |p2[127:63] : |p2[127:62];
      res = p2[63:0] << lsh;
    end else begin
      sat = |sh[127:64];
      res = sh[63:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= s2.vld & ~rst;
    case (s2.kind)
      K_CONST: begin
        rate_value <= prefactor;
        status     <= ST_OK;
      end
      K_ZERO: begin
        rate_value <= '0;
        status     <= ST_ZERO;
      end
      K_BIG: begin
        if (s2.neg && prefactor != '0) begin
          rate_value <= '1;
          status     <= ST_SAT;
        end else begin
          rate_value <= '0;
          status     <= ST_OK;
        end
      end
      default: begin
        if (sat) begin
          rate_value <= '1;
          status     <= ST_SAT;
        end else begin
          rate_value <= res;
          status     <= ST_OK;
        end
      end
    endcase
  end

endmodule

FILE: rtl/reaction_rate_constant_eval_unit.sv
// throughput: one request per cycle outside reset (fully pipelined divider and series)
// the receiver cannot stall: every result shows on the ports for exactly one cycle
// reset (rst, synchronous) flushes all in-flight requests and restores register defaults
// busy is high only while rst is high
module reaction_rate_constant_eval_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] temperature,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [63:0] rate_value,
  output logic [1:0]  status
);
  import rrce_pkg::*;

  // configuration registers; user writes them only with no request in flight (unchecked)
  logic [1:0]  model_mode;
  logic [63:0] prefactor;
  logic [31:0] base_energy;
  logic [16:0] transfer_coeff;
  logic [31:0] reaction_enthalpy;
  logic [31:0] gas_constant;

  // stage interfaces
  side_t       side_fd, side_de, side_es;
  logic [48:0] mag_fd;
  logic [51:0] rt_fd;
  logic [37:0] t_de;
  logic [6:0]  m_es;
  logic [63:0] f_es;
  logic        in_vld;

  // the pipeline never stalls, so a request is refused only in reset
  assign busy   = rst;
  assign in_vld = start & ~busy;

  // unknown register indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      model_mode        <= MODE_CONST;
      prefactor         <= 64'h0000_0001_0000_0000;
      base_energy       <= '0;
      transfer_coeff    <= 17'd32768;
      reaction_enthalpy <= '0;
      gas_constant      <= 32'd139486;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:  model_mode        <= cfg_data[1:0];
        REG_PREF:  prefactor         <= cfg_data;
        REG_BASE:  base_energy       <= cfg_data[31:0];
        REG_GAMMA: transfer_coeff    <= cfg_data[16:0];
        REG_DH:    reaction_enthalpy <= cfg_data[31:0];
        REG_GAS:   gas_constant      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // products, energy clamp, magnitude and large-exponent check (4 stages)
  rrce_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_vld            (in_vld),
    .temperature       (temperature),
    .model_mode        (model_mode),
    .base_energy       (base_energy),
    .transfer_coeff    (transfer_coeff),
    .reaction_enthalpy (reaction_enthalpy),
    .gas_constant      (gas_constant),
    .side_o            (side_fd),
    .mag_o             (mag_fd),
    .rt_o              (rt_fd)
  );

  // |E| / (R*T) as Q6.32, one quotient bit per stage (38 stages)
  rrce_div u_div (
    .clk    (clk),
    .rst    (rst),
    .side_i (side_fd),
    .mag_i  (mag_fd),
    .rt_i   (rt_fd),
    .side_o (side_de),
    .q_o    (t_de)
  );

  // base-2 split and 25-term exponential series (178 stages)
  rrce_exp u_exp (
    .clk    (clk),
    .rst    (rst),
    .side_i (side_de),
    .t_i    (t_de),
    .side_o (side_es),
    .m_o    (m_es),
    .f_o    (f_es)
  );

  // prefactor product, power-of-two scaling, saturation and output register
  rrce_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .side_i     (side_es),
    .m_i        (m_es),
    .f_i        (f_es),
    .prefactor  (prefactor),
    .done       (done),
    .rate_value (rate_value),
    .status     (status)
  );

endmodule

FILE: rtl/rrce_checker.sv
`include "reaction_rate_constant_eval_unit_assert.svh"

module rrce_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] rate_value,
  input logic [1:0]  status
);
  import rrce_pkg::*;

  `RRCE_ASSERT_NXT(a_reset_flush, rst, !done, "result strobe right after reset")
  `RRCE_ASSERT_IMP(a_never_busy, start, !busy, "request refused outside reset")
  `RRCE_ASSERT_IMP(a_zero_temp, done && status == ST_ZERO, rate_value == '0, "zero temp rate")
  `RRCE_ASSERT_IMP(a_sat_ones, done && status == ST_SAT, &rate_value, "saturated rate not all ones")

endmodule

bind reaction_rate_constant_eval_unit rrce_checker u_rrce_checker (.*);

FILE: tb/reaction_rate_constant_eval_unit_test.sv
`timescale 1ns / 100ps

module reaction_rate_constant_eval_unit_test;
  import rrce_pkg::*;

  // log2(e) in Q1.32
  localparam logic [63:0] LOG2E_Q32 = 64'd6196328019;
  // writes to these indexes must be ignored
  localparam logic [2:0]  REG_SPARE0 = 3'd6;
  localparam logic [2:0]  REG_SPARE1 = 3'd7;
  localparam logic [1:0]  MODE_SPARE = 2'd3;
  localparam int          PIPE_DEPTH = 222;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASES = 15;
  localparam int          REQS_PER_PHASE = 110;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [19:0] temperature;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;
  logic        done;
  logic [63:0] rate_value;
  logic [1:0]  status;

  reaction_rate_constant_eval_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .temperature(temperature),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .done(done),
    .rate_value(rate_value),
    .status(status)
  );

  typedef struct packed {
    logic [63:0] rate;
    logic [1:0]  st;
  } rate_result_t;

  // directed row: either a register write or a request, with an optional typed-in answer
  typedef struct {
    bit          wr;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [19:0] temp;
    bit          known;
    logic [63:0] rate;
    logic [1:0]  st;
  } rate_row_t;

  // shadow copy of the configuration registers
  logic [1:0]  mode_q;
  logic [63:0] pref_q;
  logic [31:0] base_q;
  logic [16:0] gamma_q;
  logic [31:0] dh_q;
  logic [31:0] gas_q;

  rate_result_t pending_rates[$];
  int           failures;
  int           stall_cycles;
  bit           idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bit-exact rate constant for one temperature under the shadow configuration
  function automatic rate_result_t rate_for(input logic [19:0] temp);
    rate_result_t r;
    logic [63:0]  rt, mag, whole, frac, t, u, m, g, z, sum, term;
    logic [127:0] p;
    logic [191:0] w;
    longint       e, dh, gam;
    int           k;
    bit           neg;
    r.st = ST_OK;
    // constant mode, and the unused mode code, return the prefactor as is
    if (mode_q != MODE_ARRH && mode_q != MODE_LFER) begin
      r.rate = pref_q;
      return r;
    end
    if (temp == 0 || gas_q == 0) begin
      r.rate = '0;
      r.st = ST_ZERO;
      return r;
    end
    rt = 64'(gas_q) * 64'(temp);
    e = longint'($signed(base_q)) * 65536;
    if (mode_q == MODE_LFER) begin
      dh = longint'($signed(dh_q));
      gam = (gamma_q > 17'd65536) ? 65536 : longint'(gamma_q);
      e = e + gam * dh;
      if (e < 0) e = 0;
      if (e < dh * 65536) e = dh * 65536;
    end
    neg = (e < 0);
    mag = neg ? 64'(-e) : 64'(e);
    whole = mag / rt;
    // exponent out of range: underflow to zero or saturate
    if (whole >= 45) begin
      if (neg && pref_q != 0) begin
        r.rate = '1;
        r.st = ST_SAT;
      end else begin
        r.rate = '0;
      end
      return r;
    end
    p = 128'(mag % rt) << 32;
    frac = 64'(p / rt);
    t = (whole << 32) | frac;
    p = 128'(t) * 128'(LOG2E_Q32);
    u = p[95:32];
    m = u >> 32;
    g = {32'b0, u[31:0]};
    z = (g * 64'(LN2_Q32)) >> 2;
    sum = ONE_Q62;
    term = ONE_Q62;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      p = 128'(term) * 128'(z);
      term = p[125:62] / 64'(n);
      if (!neg && n[0]) sum = sum - term;
      else sum = sum + term;
    end
    p = 128'(pref_q) * 128'(sum);
    w = {64'b0, p};
    k = neg ? int'(m) - 62 : -(62 + int'(m));
    if (k >= 0) w = w << k;
    else w = w >> (-k);
    if (|w[191:64]) begin
      r.rate = '1;
      r.st = ST_SAT;
    end else begin
      r.rate = w[63:0];
    end
    return r;
  endfunction

  // register write, only once the pipeline has drained
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    start <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      REG_MODE:  mode_q = data[1:0];
      REG_PREF:  pref_q = data;
      REG_BASE:  base_q = data[31:0];
      REG_GAMMA: gamma_q = data[16:0];
      REG_DH:    dh_q = data[31:0];
      REG_GAS:   gas_q = data[31:0];
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // issue one request; start stays high on return so back-to-back requests need no gap
  task automatic send_request(input logic [19:0] temp, input bit known,
                              input rate_result_t answer);
    cfg_we <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    temperature <= temp;
    do @(posedge clk); while (busy);
    pending_rates.push_back(known ? answer : rate_for(temp));
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (done) begin
        if (pending_rates.size() == 0) begin
          $display("%0t: unexpected result rate %h status %0d", $time, rate_value, status);
          failures <= failures + 1;
        end else begin
          if (rate_value !== pending_rates[0].rate || status !== pending_rates[0].st) begin
            $display("%0t: mismatch expected rate %h status %0d, actual rate %h status %0d",
                     $time, pending_rates[0].rate, pending_rates[0].st, rate_value, status);
            failures <= failures + 1;
          end
          void'(pending_rates.pop_front());
        end
      end
    end
  end

  rate_row_t directed[] = '{
    // reset config: constant mode, prefactor 1.0
    '{0, REG_MODE, 0, 20'd100, 1, 64'h1_0000_0000, ST_OK},
    '{0, REG_MODE, 0, 20'd0, 1, 64'h1_0000_0000, ST_OK},
    '{1, REG_MODE, 64'(MODE_ARRH), 0, 0, 0, ST_OK},
    // zero temperature outside constant mode
    '{0, REG_MODE, 0, 20'd0, 1, 64'd0, ST_ZERO},
    // zero energy gives the prefactor
    '{0, REG_MODE, 0, 20'hFFFFF, 1, 64'h1_0000_0000, ST_OK},
    '{1, REG_BASE, 64'h7FFF_FFFF, 0, 0, 0, ST_OK},
    // huge positive exponent underflows to zero
    '{0, REG_MODE, 0, 20'd1, 1, 64'd0, ST_OK},
    '{0, REG_MODE, 0, 20'hFFFFF, 0, 0, ST_OK},
    '{1, REG_BASE, 64'h8000_0000, 0, 0, 0, ST_OK},
    // huge negative exponent saturates
    '{0, REG_MODE, 0, 20'd1, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_SAT},
    '{1, REG_PREF, 64'd0, 0, 0, 0, ST_OK},
    // ... unless the prefactor is zero
    '{0, REG_MODE, 0, 20'd1, 1, 64'd0, ST_OK},
    '{1, REG_PREF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, ST_OK},
    '{1, REG_BASE, 64'hFFFF_0000, 0, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'd76800, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'hFFFFF, 0, 0, ST_OK},
    // zero gas constant acts like zero temperature
    '{1, REG_GAS, 64'd0, 0, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'd500, 1, 64'd0, ST_ZERO},
    '{1, REG_GAS, 64'hFFFF_FFFF, 0, 0, 0, ST_OK},
    '{1, REG_MODE, 64'(MODE_LFER), 0, 0, 0, ST_OK},
    // gamma above one is clamped
    '{1, REG_GAMMA, 64'h1FFFF, 0, 0, 0, ST_OK},
    '{1, REG_DH, 64'h0010_0000, 0, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'd76800, 0, 0, ST_OK},
    '{1, REG_DH, 64'h8000_0000, 0, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'd3, 0, 0, ST_OK},
    // spare indexes must not disturb anything
    '{1, REG_SPARE0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, ST_OK},
    '{1, REG_SPARE1, 64'd0, 0, 0, 0, ST_OK},
    // unused mode code behaves as constant mode
    '{1, REG_MODE, 64'(MODE_SPARE), 0, 0, 0, ST_OK},
    '{0, REG_MODE, 0, 20'd5, 1, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK}
  };

  initial begin
    rate_result_t ans;
    logic [63:0]  pick;
    longint       gas_v, t0, base_v;
    int           lo_t, hi_t, sel;
    rst = 1'b1;
    start = 1'b0;
    temperature = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    failures = 0;
    stall_cycles = 0;
    idle_on = 1'b1;
    mode_q = MODE_CONST;
    pref_q = 64'h1_0000_0000;
    base_q = '0;
    gamma_q = 17'd32768;
    dh_q = '0;
    gas_q = 32'd139486;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].wr) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        ans.rate = directed[i].rate;
        ans.st = directed[i].st;
        send_request(directed[i].temp, directed[i].known, ans);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // no idling in the closing phase
      idle_on = (ph < PHASES - 1);
      sel = $urandom_range(0, 9);
      write_reg(REG_MODE, sel < 4 ? 64'(MODE_ARRH) : sel < 8 ? 64'(MODE_LFER) :
                          sel < 9 ? 64'(MODE_CONST) : 64'(MODE_SPARE));
      if (ph % 4 == 3) begin
        // corner settings
        case ($urandom_range(0, 2))
          0: pick = 64'd0;
          1: pick = 64'hFFFF_FFFF_FFFF_FFFF;
          default: pick = {$urandom(), $urandom()};
        endcase
        write_reg(REG_PREF, pick);
        write_reg(REG_BASE, $urandom_range(0, 1) ? 64'h7FFF_FFFF : 64'h8000_0000);
        write_reg(REG_GAMMA, $urandom_range(0, 1) ? 64'd0 : 64'h1FFFF);
        write_reg(REG_DH, $urandom_range(0, 1) ? 64'h7FFF_FFFF : 64'h8000_0000);
        write_reg(REG_GAS, $urandom_range(0, 1) ? 64'd1 : 64'hFFFF_FFFF);
        t0 = $urandom_range(1, 20'hFFFFF);
      end else begin
        // place E/RT in the interesting 0..60 range around a center temperature
        gas_v = $urandom_range(1 << 16, 1 << 26);
        t0 = $urandom_range(256, 1 << 18);
        base_v = longint'($urandom_range(0, 60)) * gas_v * t0 / 65536;
        if (base_v > 64'sh7FFF_FFFF) base_v = 64'sh7FFF_FFFF;
        if ($urandom_range(0, 1)) base_v = -base_v;
        write_reg(REG_PREF, {$urandom(), $urandom()} >> $urandom_range(0, 40));
        write_reg(REG_BASE, 64'(base_v));
        write_reg(REG_GAMMA, $urandom_range(0, 7) == 0 ? $urandom_range(65537, 131071)
                                                      : $urandom_range(0, 65536));
        write_reg(REG_DH, 64'($signed($urandom()) >>> $urandom_range(0, 16)));
        write_reg(REG_GAS, 64'(gas_v));
      end
      lo_t = int'(t0 / 2);
      hi_t = (t0 * 2 > 20'hFFFFF) ? 20'hFFFFF : int'(t0 * 2);
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) send_request(20'($urandom_range(lo_t, hi_t)), 0, ans);
        else if (sel < 9) send_request(20'($urandom_range(0, 20'hFFFFF)), 0, ans);
        else send_request(20'($urandom_range(0, 16)), 0, ans);
      end
    end

    start <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
